@@ src/nhb_pkg.sv @@
package nhb_pkg;

	// hash geometry
	localparam int HASH_BITS = 32;
	localparam int CNT_W     = $clog2(HASH_BITS);
	localparam logic [HASH_BITS-1:0] HASH_SEED = 32'h0000_5555;

	// table sizes and bucket index
	localparam int SIZE_W  = 21;
	localparam int INDEX_W = 20;
	localparam logic [SIZE_W-1:0] MAX_BUCKETS        = 21'h10_0000;
	localparam logic [SIZE_W-1:0] CLIENT_SIZE_RESET  = 21'd6007;
	localparam logic [SIZE_W-1:0] CHANNEL_SIZE_RESET = 21'd2003;

	// register map
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_CLIENT_SIZE  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_CHANNEL_SIZE = 2'd1;

	// table select codes
	localparam logic TABLE_CLIENT  = 1'b0;
	localparam logic TABLE_CHANNEL = 1'b1;

	// one finished name waiting for its modulo
	typedef struct packed {
		logic [HASH_BITS-1:0] magnitude;
		logic [SIZE_W-1:0]    divisor;
	} queue_entry_t;

	// handshake between queue and divider
	typedef struct packed {
		logic valid;
		logic ready;
	} hs_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} back_state_t;

	// A-Z to a-z
	function automatic logic [7:0] fold_case(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= 8'h41 && b <= 8'h5A) begin
			r = b + 8'h20;
		end
		return r;
	endfunction

endpackage

@@ src/nhb_if.sv @@
interface nhb_byte_if import nhb_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] name_byte;
	logic       byte_present;
	logic       last_byte;
	logic       table_choice;

	modport source(output valid, name_byte, byte_present, last_byte, table_choice,
		input ready);
	modport sink(input valid, name_byte, byte_present, last_byte, table_choice,
		output ready);
endinterface

interface nhb_result_if import nhb_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [INDEX_W-1:0]   bucket_index;
	logic [HASH_BITS-1:0] hash_magnitude;

	modport source(output valid, bucket_index, hash_magnitude, input ready);
	modport sink(input valid, bucket_index, hash_magnitude, output ready);
endinterface

interface nhb_cfg_if import nhb_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] index;
	logic [SIZE_W-1:0]    data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ src/nhb_front.sv @@
module nhb_front import nhb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	nhb_byte_if.sink     byte_ch,
	nhb_cfg_if.sink      cfg_ch,
	output logic         push_valid,
	input  logic         push_ready,
	output queue_entry_t push_entry
);

	logic [HASH_BITS-1:0] hash_q;
	logic [SIZE_W-1:0]    client_size_q;
	logic [SIZE_W-1:0]    channel_size_q;
	logic [HASH_BITS-1:0] hash_next;
	logic [SIZE_W-1:0]    size_sel;
	logic                 accept;

	// bytes flow while the queue has room
	assign byte_ch.ready = push_ready;
	assign accept        = byte_ch.valid && push_ready;
	assign cfg_ch.ready  = 1'b1;

	// shift-xor step on the folded byte
	always_comb begin
		hash_next = hash_q;
		if (byte_ch.byte_present) begin
			hash_next = {hash_q[HASH_BITS-3:0], 2'b00}
				^ {{(HASH_BITS-8){1'b0}}, fold_case(byte_ch.name_byte)};
		end
	end

	// magnitude and clamped divisor for the end of a name
	always_comb begin
		size_sel = (byte_ch.table_choice == TABLE_CHANNEL) ? channel_size_q : client_size_q;
		push_entry.divisor = (size_sel > MAX_BUCKETS) ? MAX_BUCKETS : size_sel;
		push_entry.magnitude = hash_next[HASH_BITS-1]
			? (~hash_next) + {{(HASH_BITS-1){1'b0}}, 1'b1} : hash_next;
	end

	assign push_valid = byte_ch.valid && byte_ch.last_byte;

	// running hash, reseeded after each name
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HASH_SEED;
		end else if (accept) begin
			hash_q <= byte_ch.last_byte ? HASH_SEED : hash_next;
		end
	end

	// table size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			client_size_q  <= CLIENT_SIZE_RESET;
			channel_size_q <= CHANNEL_SIZE_RESET;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				REG_CLIENT_SIZE:  client_size_q  <= cfg_ch.data;
				REG_CHANNEL_SIZE: channel_size_q <= cfg_ch.data;
				default: ;
			endcase
		end
	end

endmodule

@@ src/nhb_queue.sv @@
module nhb_queue import nhb_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  queue_entry_t push_entry,
	output hs_t          pop_hs_o,
	input  logic         pop_ready,
	output queue_entry_t pop_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	queue_entry_t         mem_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [FILL_W-1:0]    fill_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready     = (fill_q != FILL_W'(DEPTH));
	assign pop_hs_o.valid = (fill_q != '0);
	assign pop_hs_o.ready = pop_ready;
	assign do_push        = push_valid && push_ready;
	assign do_pop         = pop_hs_o.valid && pop_ready;
	assign pop_entry      = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

@@ src/nhb_back.sv @@
module nhb_back import nhb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         pop_valid,
	output logic         pop_ready,
	input  queue_entry_t pop_entry,
	nhb_result_if.source result_ch
);

	back_state_t          state_q;
	back_state_t          state_d;
	logic [HASH_BITS-1:0] dividend_q;
	logic [HASH_BITS-1:0] mag_q;
	logic [SIZE_W-1:0]    div_q;
	logic [INDEX_W-1:0]   rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 res_valid_q;
	logic [INDEX_W-1:0]   res_index_q;
	logic [HASH_BITS-1:0] res_mag_q;
	logic [SIZE_W-1:0]    trial;
	logic [INDEX_W-1:0]   step_rem;
	logic                 res_free;
	logic                 load_res;
	logic                 do_pop;

	assign res_free = !res_valid_q || result_ch.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (pop_valid) begin
				state_d = BK_DIV;
			end
			BK_DIV: if (cnt_q == CNT_W'(HASH_BITS - 1)) begin
				state_d = BK_DONE;
			end
			BK_DONE: if (res_free) begin
				state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		pop_ready = 1'b0;
		load_res  = 1'b0;
		unique case (state_q)
			BK_IDLE: pop_ready = 1'b1;
			BK_DIV:  ;
			BK_DONE: load_res = res_free;
			default: ;
		endcase
	end

	assign do_pop = pop_valid && pop_ready;

	// one restoring step per cycle
	always_comb begin
		trial = {rem_q, dividend_q[HASH_BITS-1]};
		if (trial >= div_q) begin
			step_rem = INDEX_W'(trial - div_q);
		end else begin
			step_rem = trial[INDEX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (do_pop) begin
				cnt_q <= '0;
			end else if (state_q == BK_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (do_pop) begin
			dividend_q <= pop_entry.magnitude;
			mag_q      <= pop_entry.magnitude;
			div_q      <= pop_entry.divisor;
			rem_q      <= '0;
		end else if (state_q == BK_DIV) begin
			dividend_q <= {dividend_q[HASH_BITS-2:0], 1'b0};
			rem_q      <= step_rem;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_index_q <= (div_q == '0) ? '0 : rem_q;
			res_mag_q   <= mag_q;
		end
	end

	assign result_ch.valid          = res_valid_q;
	assign result_ch.bucket_index   = res_index_q;
	assign result_ch.hash_magnitude = res_mag_q;

endmodule

@@ src/name_hash_bucket_index_core.sv @@
// channel    | dir  | payload
// byte_ch    | sink | name_byte, byte_present, last_byte, table_choice
// result_ch  | src  | bucket_index, hash_magnitude
// cfg_ch     | sink | index, data (0 client table size, 1 channel table size)
//
// bytes are taken one per cycle while the name queue has room
// each finished name then passes the back in turn: it is loaded, runs through
// the one-bit-per-cycle restoring divider, and its result is handed off
// a stalled result holds in the output register; the divider waits behind it,
// then the queue fills and byte_ch drops ready for every request until it drains
// reset clears the hash to its seed, the table sizes to 6007 and 2003,
// and empties queue, divider and output register
module name_hash_bucket_index_core import nhb_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	nhb_byte_if.sink     byte_ch,
	nhb_result_if.source result_ch,
	nhb_cfg_if.sink      cfg_ch
);

	logic         push_valid;
	logic         push_ready;
	queue_entry_t push_entry;
	hs_t          pop_hs;
	logic         pop_ready;
	queue_entry_t pop_entry;

	// hash and classify
	nhb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.cfg_ch    (cfg_ch),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_entry(push_entry)
	);

	// finished names awaiting the divider
	nhb_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_entry(push_entry),
		.pop_hs_o  (pop_hs),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry)
	);

	// modulo and result register
	nhb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_hs.valid),
		.pop_ready(pop_ready),
		.pop_entry(pop_entry),
		.result_ch(result_ch)
	);

endmodule

@@ src/nhb_checker.sv @@
module nhb_checker import nhb_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 res_valid,
	input logic                 res_ready,
	input logic [INDEX_W-1:0]   bucket_index,
	input logic [HASH_BITS-1:0] hash_magnitude,
	input logic                 cfg_ready
);

	// a stalled result stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(bucket_index)
			&& $stable(hash_magnitude))
		else $error("result changed while stalled");

	// magnitude never exceeds 2^31
	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !hash_magnitude[HASH_BITS-1]
			|| (hash_magnitude[HASH_BITS-2:0] == '0))
		else $error("hash magnitude out of range");

	// a remainder is never above its dividend
	a_idx_le_mag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> {{(HASH_BITS-INDEX_W){1'b0}}, bucket_index} <= hash_magnitude)
		else $error("bucket index above hash magnitude");

	// table size writes are never held off
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind name_hash_bucket_index_core nhb_checker u_nhb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (result_ch.valid),
	.res_ready     (result_ch.ready),
	.bucket_index  (result_ch.bucket_index),
	.hash_magnitude(result_ch.hash_magnitude),
	.cfg_ready     (cfg_ch.ready)
);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
	import nhb_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 7;
	// settling wait for the back end after the last result, with margin
	localparam int BACK_LATENCY  = 40;
	localparam int HOLD_CYCLES   = 600;
	localparam int RANDOM_REQS   = 1100;
	localparam int MAX_REPORTS   = 10;
	// indexes past the register map, writes there must be dropped
	localparam logic [REG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef struct {
		logic [INDEX_W-1:0]   bucket;
		logic [HASH_BITS-1:0] magnitude;
	} bucket_result_t;

	logic clk = 1'b0;
	logic arst_n;

	nhb_byte_if   byte_ch();
	nhb_result_if result_ch();
	nhb_cfg_if    cfg_ch();

	name_hash_bucket_index_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.result_ch (result_ch),
		.cfg_ch    (cfg_ch)
	);

	// hash model state and table sizes as the block should hold them
	logic [HASH_BITS-1:0] hash_now;
	logic [SIZE_W-1:0]    client_size;
	logic [SIZE_W-1:0]    channel_size;
	bucket_result_t       expected_buckets[$];
	logic [7:0]           name_buf[$];

	bit sender_idles   = 1'b1;
	bit receiver_idles = 1'b1;
	int stall_asks     = 0;
	int mismatches     = 0;
	int requests_sent  = 0;
	int names_sent     = 0;
	int results_seen   = 0;
	int size_writes    = 0;

	always #CLK_HALF clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(0, 9))
			0: return SIZE_W'($urandom_range(1, 16));
			1: return '0;
			2: return MAX_BUCKETS;
			3, 4: return SIZE_W'($urandom);
			default: return SIZE_W'($urandom_range(17, 1048576));
		endcase
	endfunction

	function automatic int pick_name_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) return 0;
		if (r < 70) return $urandom_range(1, 6);
		if (r < 95) return $urandom_range(7, 16);
		return $urandom_range(17, 40);
	endfunction

	// letters of both cases most of the time, digits or any byte otherwise
	function automatic logic [7:0] pick_name_byte();
		case ($urandom_range(0, 9))
			0, 1, 2: return 8'($urandom_range(8'h41, 8'h5A));
			3, 4, 5: return 8'($urandom_range(8'h61, 8'h7A));
			6: return 8'($urandom_range(8'h30, 8'h39));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		if (b >= 8'h41 && b <= 8'h5A) begin
			return b + 8'h20;
		end
		return b;
	endfunction

	// advance the hash model and queue the bucket a finished name should give
	task automatic update_hash_model(input logic [7:0] b, input logic present,
		input logic last, input logic choice);
		logic [HASH_BITS-1:0] mag;
		logic [SIZE_W-1:0]    div;
		bucket_result_t       want;
		if (present) begin
			hash_now = {hash_now[HASH_BITS-3:0], 2'b00} ^ {24'h0, to_lower(b)};
		end
		if (last) begin
			mag = hash_now[HASH_BITS-1] ? (~hash_now + 1'b1) : hash_now;
			div = (choice == TABLE_CHANNEL) ? channel_size : client_size;
			if (div > MAX_BUCKETS) begin
				div = MAX_BUCKETS;
			end
			want.magnitude = mag;
			want.bucket    = (div == '0) ? '0 : INDEX_W'(mag % div);
			expected_buckets.push_back(want);
			hash_now = HASH_SEED;
		end
	endtask

	// one byte request; valid stays high into the next call when no gap follows
	task automatic send_request(input logic [7:0] b, input logic present,
		input logic last, input logic choice);
		int gap;
		gap = sender_idles ? pick_gap() : 0;
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid        <= 1'b1;
		byte_ch.name_byte    <= b;
		byte_ch.byte_present <= present;
		byte_ch.last_byte    <= last;
		byte_ch.table_choice <= choice;
		do @(posedge clk); while (!byte_ch.ready);
		update_hash_model(b, present, last, choice);
		if (present || last) begin
			requests_sent++;
		end
		if (last) begin
			names_sent++;
		end
	endtask

	// send name_buf as one name; an empty buffer gives the empty name
	task automatic send_name(input logic choice, input bit split_end, input bit with_idles);
		int n;
		n = name_buf.size();
		for (int i = 0; i < n; i++) begin
			if (with_idles && $urandom_range(0, 7) == 0) begin
				send_request(8'($urandom), 1'b0, 1'b0, 1'($urandom));
			end
			send_request(name_buf[i], 1'b1, (i == n - 1) && !split_end,
				(i == n - 1) ? choice : 1'($urandom));
		end
		if (n == 0 || split_end) begin
			send_request(8'($urandom), 1'b0, 1'b1, choice);
		end
		name_buf.delete();
	endtask

	task automatic build_name(input int len);
		repeat (len) name_buf.push_back(pick_name_byte());
	endtask

	// 0xd4 then twelve zero bytes lands the hash exactly on 0x80000000
	task automatic load_min_hash_name();
		name_buf = {8'hD4};
		repeat (12) name_buf.push_back(8'h00);
	endtask

	// let every pending name come out before touching the registers
	task automatic settle_block();
		byte_ch.valid <= 1'b0;
		while (expected_buckets.size() != 0) @(posedge clk);
		repeat (BACK_LATENCY) @(posedge clk);
	endtask

	task automatic write_size_reg(input logic [REG_IDX_W-1:0] idx,
		input logic [SIZE_W-1:0] value);
		settle_block();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_CLIENT_SIZE: client_size = value;
			REG_CHANNEL_SIZE: channel_size = value;
			default: ;
		endcase
		size_writes++;
	endtask

	// the smallest hash plus a short random name on each table
	task automatic probe_tables();
		for (int t = 0; t < 2; t++) begin
			load_min_hash_name();
			send_name(1'(t), 1'b0, 1'b0);
			build_name($urandom_range(1, 4));
			send_name(1'(t), 1'b0, 1'b0);
		end
	endtask

	task automatic resize_and_probe(input logic [SIZE_W-1:0] client,
		input logic [SIZE_W-1:0] channel);
		write_size_reg(REG_CLIENT_SIZE, client);
		write_size_reg(REG_CHANNEL_SIZE, channel);
		probe_tables();
	endtask

	task automatic check_bucket_result();
		bucket_result_t want;
		results_seen++;
		if (expected_buckets.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS) begin
				$display("%0t: result with no name pending: bucket %0d hash 0x%08h",
					$realtime, result_ch.bucket_index, result_ch.hash_magnitude);
			end
			return;
		end
		want = expected_buckets.pop_front();
		if (result_ch.bucket_index !== want.bucket ||
			result_ch.hash_magnitude !== want.magnitude) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS) begin
				$display("%0t: result %0d: expected bucket %0d hash 0x%08h, got bucket %0d hash 0x%08h",
					$realtime, results_seen, want.bucket, want.magnitude,
					result_ch.bucket_index, result_ch.hash_magnitude);
			end
		end
	endtask

	// result side: random ready gaps, and a long hold whenever one is asked
	initial begin : result_sink
		int gap_left;
		int hold_left;
		int stall_done;
		gap_left   = 0;
		hold_left  = 0;
		stall_done = 0;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				check_bucket_result();
			end
			if (hold_left == 0 && stall_done != stall_asks) begin
				stall_done = stall_asks;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				if (receiver_idles && $urandom_range(0, 3) == 0) begin
					gap_left = pick_gap();
				end
			end
		end
	end

	// empty names, case folding edges, extreme bytes, the most negative hash
	task automatic test_reset_sizes();
		send_name(TABLE_CLIENT, 1'b0, 1'b0);
		send_request(8'hA5, 1'b0, 1'b0, TABLE_CHANNEL);
		send_name(TABLE_CHANNEL, 1'b0, 1'b0);
		// 0x00 0xff A Z @ [
		name_buf = {8'h00, 8'hFF, 8'h41, 8'h5A, 8'h40, 8'h5B};
		send_name(TABLE_CLIENT, 1'b0, 1'b0);
		// a z ` {, name closed by a request without a byte
		name_buf = {8'h61, 8'h7A, 8'h60, 8'h7B};
		send_name(TABLE_CHANNEL, 1'b1, 1'b0);
		load_min_hash_name();
		send_name(TABLE_CHANNEL, 1'b0, 1'b0);
	endtask

	// divisor of one, zero, the top size, clamped sizes, and ignored indexes
	task automatic test_table_sizes();
		resize_and_probe(21'd1, 21'd0);
		resize_and_probe(MAX_BUCKETS, MAX_BUCKETS + 21'd1);
		resize_and_probe('1, 21'd7);
		resize_and_probe(21'd999983, 21'd2);
		write_size_reg(REG_SPARE_2, '1);
		write_size_reg(REG_SPARE_3, 21'h0A5A5);
		probe_tables();
	endtask

	// hold results back while short names stream in and stall the input
	task automatic test_output_stall();
		sender_idles = 1'b0;
		stall_asks <= stall_asks + 1;
		repeat (40) begin
			build_name($urandom_range(1, 3));
			send_name(1'($urandom), 1'b0, 1'b0);
		end
		sender_idles = 1'b1;
	endtask

	// phases of random names, each under fresh table sizes and idle settings
	task automatic test_random(input int target);
		int start;
		int phase_end;
		start = requests_sent;
		while (requests_sent - start < target) begin
			write_size_reg(REG_CLIENT_SIZE, pick_size());
			write_size_reg(REG_CHANNEL_SIZE, pick_size());
			if ($urandom_range(0, 3) == 0) begin
				write_size_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_2 : REG_SPARE_3,
					SIZE_W'($urandom));
			end
			sender_idles = ($urandom_range(0, 3) != 0);
			receiver_idles <= ($urandom_range(0, 3) != 0);
			phase_end = requests_sent + $urandom_range(120, 220);
			while (requests_sent < phase_end) begin
				if ($urandom_range(0, 19) == 0) begin
					send_request(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
				end else begin
					build_name(pick_name_len());
					send_name(1'($urandom), $urandom_range(0, 5) == 0,
						$urandom_range(0, 4) == 0);
				end
			end
			// close whatever name noise left open
			send_request(8'($urandom), 1'b0, 1'b1, 1'($urandom));
		end
	endtask

	initial begin : run
		byte_ch.valid        <= 1'b0;
		byte_ch.name_byte    <= '0;
		byte_ch.byte_present <= 1'b0;
		byte_ch.last_byte    <= 1'b0;
		byte_ch.table_choice <= 1'b0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.index         <= '0;
		cfg_ch.data          <= '0;
		arst_n               <= 1'b0;
		hash_now     = HASH_SEED;
		client_size  = CLIENT_SIZE_RESET;
		channel_size = CHANNEL_SIZE_RESET;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_sizes();
		test_table_sizes();
		test_output_stall();
		test_random(RANDOM_REQS);
		settle_block();

		$display("covered %0d names in %0d byte requests, %0d register writes",
			names_sent, requests_sent, size_writes);
		$display("checked %0d results, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0 && expected_buckets.size() == 0) begin
			$display("** name_hash_bucket_index_core: PASSED **");
		end else begin
			$display("** name_hash_bucket_index_core: FAILED **");
		end
		$finish;
	end

	initial begin : watchdog
		#10ms;
		$display("timeout with %0d results pending", expected_buckets.size());
		$display("** name_hash_bucket_index_core: FAILED **");
		$finish;
	end

endmodule
